/* rtl/signature_reuse_cache_replacement_top_macros.svh */
// Assertion macros shared by the replacement engine.
`ifndef SIGNATURE_REUSE_CACHE_REPLACEMENT_TOP_MACROS_SVH
`define SIGNATURE_REUSE_CACHE_REPLACEMENT_TOP_MACROS_SVH

// Implication checked every clock outside reset.
`define SRCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked every clock outside reset.
`define SRCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/srcr_pkg.sv */
package srcr_pkg;

  localparam int unsigned FuncWidth = 1;
  localparam int unsigned SetWidth  = 11;
  localparam int unsigned WayWidth  = 4;
  localparam int unsigned PcWidth   = 10;
  localparam int unsigned SigWidth  = 10;
  localparam int unsigned CtrWidth  = 3;

  localparam logic [CtrWidth-1:0] CtrMax  = 3'd7;
  localparam logic [CtrWidth-1:0] CtrInit = 3'd1;
  localparam logic [CtrWidth-1:0] CtrHot  = 3'd3;

  localparam logic FuncVictim = 1'b0;
  localparam logic FuncUpdate = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CTR,
    ST_EXEC,
    ST_RESP
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;    // write reset values at the sweep address
    logic capture;     // register the accepted beat
    logic read_en;     // read the set row
    logic ctr_rd;      // read the old and new signature counters
    logic exec_en;     // modify and write back
    logic out_load;    // load the victim into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic is_victim;
  } dp_status_t;

endpackage

/* rtl/srcr_ctrl.sv */
module srcr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  srcr_pkg::dp_status_t  status,
  output srcr_pkg::ctrl_cmd_t   cmd
);
  import srcr_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_en = 1'b1;
        // A victim query needs no counter, so it skips the counter read.
        state_nxt   = status.is_victim ? ST_EXEC : ST_CTR;
      end
      ST_CTR: begin
        cmd.ctr_rd = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec_en  = 1'b1;
        cmd.out_load = status.is_victim;
        state_nxt    = status.is_victim ? ST_RESP : ST_IDLE;
      end
      ST_RESP: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

endmodule

/* rtl/srcr_datapath.sv */
module srcr_datapath #(
  parameter int unsigned NUM_SETS              = 2048,
  parameter int unsigned NUM_WAYS              = 16,
  parameter int unsigned COUNTER_TABLE_ENTRIES = 1024,
  parameter int unsigned RRPV_WIDTH            = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srcr_pkg::ctrl_cmd_t            cmd,
  input  logic [srcr_pkg::FuncWidth-1:0] in_func,
  input  logic [srcr_pkg::SetWidth-1:0]  in_set,
  input  logic [srcr_pkg::WayWidth-1:0]  in_way,
  input  logic                           in_hit,
  input  logic [srcr_pkg::PcWidth-1:0]   in_pc,
  input  logic [srcr_pkg::PcWidth-1:0]   in_page,
  output srcr_pkg::dp_status_t           status,
  output logic [srcr_pkg::WayWidth-1:0]  victim_way
);
  import srcr_pkg::*;

  localparam int unsigned SetAw = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned CtrAw = $clog2(COUNTER_TABLE_ENTRIES);
  localparam int unsigned WayAw = $clog2(NUM_WAYS);
  localparam int unsigned ClrW  = (SetAw > CtrAw ? SetAw : CtrAw) + 1;
  localparam int unsigned LineW = RRPV_WIDTH + SigWidth + 1;
  localparam int unsigned RowW  = NUM_WAYS * LineW;
  localparam logic [RRPV_WIDTH-1:0] RrpvTop  = '1;
  localparam logic [RRPV_WIDTH-1:0] RrpvCold = RrpvTop - 1'b1;

  // Remainders by the set count and the table size use a reciprocal
  // multiply; the shift is wide enough that the quotient is exact for
  // every input value.
  localparam int unsigned SetK  = SetWidth + SetAw;
  localparam longint unsigned SetM =
    ((64'd1 << SetK) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
  localparam int unsigned SetPw = SetWidth + SetK + 1;
  localparam int unsigned CtrK  = SigWidth + CtrAw;
  localparam longint unsigned CtrM =
    ((64'd1 << CtrK) + 64'(COUNTER_TABLE_ENTRIES) - 64'd1) / 64'(COUNTER_TABLE_ENTRIES);
  localparam int unsigned CtrPw = SigWidth + CtrK + 1;

  // Each line: {rrpv, signature, referenced}.
  logic [RowW-1:0]     row_mem [NUM_SETS];
  logic [CtrWidth-1:0] ctr_mem [COUNTER_TABLE_ENTRIES];

  logic [ClrW-1:0]         clr_r;
  logic                    func_r, hit_r, way_ok_r;
  logic [SetAw-1:0]        set_r;
  logic [WayAw-1:0]        way_r;
  logic [CtrAw-1:0]        sig_r;
  logic [RowW-1:0]         row_q_r;
  logic [CtrWidth-1:0]     new_ctr_q_r;
  logic [CtrWidth-1:0]     old_ctr_q_r;
  logic [WayWidth-1:0]     victim_r;

  logic [SetPw-1:0]        set_prod;
  logic [SetWidth-1:0]     set_quo, set_rem;
  logic [SigWidth-1:0]     sig_raw, sig_quo, sig_rem;
  logic [CtrPw-1:0]        sig_prod;
  logic [SetAw-1:0]        set_cap;
  logic [CtrAw-1:0]        old_sig;
  logic [RowW-1:0]         row_nxt;
  logic [RRPV_WIDTH-1:0]   top, age;
  logic [WayWidth-1:0]     vic;
  logic                    found;
  logic [LineW-1:0]        ln;
  logic                    old_ref;
  logic [CtrWidth-1:0]     old_ctr_upd, new_ctr_eff;
  logic                    ctr_wr;

  assign set_prod = SetPw'(in_set) * SetPw'(SetM);
  assign set_quo  = SetWidth'(set_prod >> SetK);
  assign set_rem  = in_set - SetWidth'(32'(set_quo) * NUM_SETS);
  assign set_cap  = SetAw'(set_rem);

  assign sig_raw  = in_pc ^ in_page;
  assign sig_prod = CtrPw'(sig_raw) * CtrPw'(CtrM);
  assign sig_quo  = SigWidth'(sig_prod >> CtrK);
  assign sig_rem  = sig_raw - SigWidth'(32'(sig_quo) * COUNTER_TABLE_ENTRIES);

  assign old_sig = CtrAw'(row_q_r[way_r*LineW+1 +: SigWidth]);
  assign old_ref = row_q_r[way_r*LineW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_en && !status.clear_done) begin
      clr_r <= clr_r + 1'b1;
    end
  end
  assign status.clear_done = (clr_r >= ClrW'(NUM_SETS)) &&
                             (clr_r >= ClrW'(COUNTER_TABLE_ENTRIES));
  assign status.is_victim  = (func_r == FuncVictim);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= in_func;
      hit_r    <= in_hit;
      set_r    <= set_cap;
      way_r    <= WayAw'(in_way);
      way_ok_r <= (32'(in_way) < NUM_WAYS);
      sig_r    <= CtrAw'(sig_rem);
    end
    if (cmd.out_load) begin
      victim_r <= vic;
    end
  end

  // Row memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      row_q_r <= row_mem[set_r];
    end
    if (cmd.clear_en && 32'(clr_r) < NUM_SETS) begin
      row_mem[SetAw'(clr_r)] <= {NUM_WAYS{RrpvTop, {SigWidth{1'b0}}, 1'b0}};
    end else if (cmd.exec_en) begin
      row_mem[set_r] <= row_nxt;
    end
  end

  // Counter memory: two reads (old and new signature), one write. The old
  // signature comes from the registered row, so the reads follow the row read.
  always_ff @(posedge clk) begin
    if (cmd.ctr_rd) begin
      old_ctr_q_r <= ctr_mem[old_sig];
      new_ctr_q_r <= ctr_mem[sig_r];
    end
    if (cmd.clear_en && 32'(clr_r) < COUNTER_TABLE_ENTRIES) begin
      ctr_mem[CtrAw'(clr_r)] <= CtrInit;
    end else if (ctr_wr) begin
      ctr_mem[old_sig] <= old_ctr_upd;
    end
  end

  always_comb begin
    old_ctr_upd = old_ctr_q_r;
    if (old_ref) begin
      if (old_ctr_q_r < CtrMax) old_ctr_upd = old_ctr_q_r + 1'b1;
    end else begin
      if (old_ctr_q_r != '0) old_ctr_upd = old_ctr_q_r - 1'b1;
    end
    ctr_wr = cmd.exec_en && func_r == FuncUpdate && way_ok_r && !hit_r;
    // When the old and new signatures match, the new counter sees the update.
    new_ctr_eff = (old_sig == sig_r) ? old_ctr_upd : new_ctr_q_r;
  end

  always_comb begin
    top = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row_q_r[w*LineW+1+SigWidth +: RRPV_WIDTH] > top)
        top = row_q_r[w*LineW+1+SigWidth +: RRPV_WIDTH];
    end
    age     = RrpvTop - top;
    row_nxt = row_q_r;
    vic     = '0;
    found   = 1'b0;
    ln      = '0;
    if (func_r == FuncVictim) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        row_nxt[w*LineW+1+SigWidth +: RRPV_WIDTH] =
          row_q_r[w*LineW+1+SigWidth +: RRPV_WIDTH] + age;
        if (!found && row_nxt[w*LineW+1+SigWidth +: RRPV_WIDTH] == RrpvTop) begin
          found = 1'b1;
          vic   = WayWidth'(w);
        end
      end
    end else if (way_ok_r) begin
      ln = row_q_r[way_r*LineW +: LineW];
      if (hit_r) begin
        ln = {{RRPV_WIDTH{1'b0}}, ln[SigWidth:1], 1'b1};
      end else begin
        ln = {(new_ctr_eff > CtrHot) ? {RRPV_WIDTH{1'b0}} : RrpvCold,
              SigWidth'(sig_r), 1'b0};
      end
      row_nxt[way_r*LineW +: LineW] = ln;
    end
  end

  assign victim_way = victim_r;

endmodule

/* rtl/signature_reuse_cache_replacement_top.sv */
// Signature-based reuse cache replacement engine (SHiP over 2-bit RRIP).
// Input channel in_*: one beat per request. in_tdata carries func, set_index,
// way_index, hit, pc_low and addr_page_bits from the lowest bit up. A victim
// query (func 0) ages its set and returns one beat on out_* carrying the
// lowest way at the maximum prediction value. An update (func 1) returns
// no beat: a hit marks the line hot and referenced; a miss trains the
// counter of the evicted line's signature and fills under a new one.
// An update steps through accept, a registered read of the set row, a
// registered read of the old and new signature counters, then the modify
// and write back; the next beat can be accepted in the cycle after that.
// A victim query takes accept, row read, then aging with write back and
// the victim loaded into the output register; its beat is offered in the
// following cycle. The block accepts no new request while that beat
// waits, so a stalled receiver holds off the next request.
// After reset the block sweeps the row and counter memories, one entry of
// each per cycle, until every entry of both has been written, with
// in_tready low throughout. Updates to ways at or above NUM_WAYS are
// dropped. Sets are taken modulo NUM_SETS.
module signature_reuse_cache_replacement_top #(
  parameter int unsigned NUM_SETS              = 2048,
  parameter int unsigned NUM_WAYS              = 16,
  parameter int unsigned COUNTER_TABLE_ENTRIES = 1024,
  parameter int unsigned RRPV_WIDTH            = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // func, set_index, way_index, hit, pc_low, addr_page_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // victim_way, zero fill
);
  import srcr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [WayWidth-1:0] victim_way;

  srcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  srcr_datapath #(
    .NUM_SETS              (NUM_SETS),
    .NUM_WAYS              (NUM_WAYS),
    .COUNTER_TABLE_ENTRIES (COUNTER_TABLE_ENTRIES),
    .RRPV_WIDTH            (RRPV_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_func    (in_tdata[0]),
    .in_set     (in_tdata[11:1]),
    .in_way     (in_tdata[15:12]),
    .in_hit     (in_tdata[16]),
    .in_pc      (in_tdata[26:17]),
    .in_page    (in_tdata[36:27]),
    .status     (status),
    .victim_way (victim_way)
  );

  assign out_tdata = {4'b0, victim_way};

`include "signature_reuse_cache_replacement_top_macros.svh"

  // A request is never taken while a victim beat is pending.
  `SRCR_ASSERT_IMP(a_no_accept_busy, out_tvalid, !in_tready, "accept while result pending")
  // Only a victim query produces a result beat.
  `SRCR_ASSERT_IMP(a_load_victim, cmd.out_load, status.is_victim, "result for update")
  // An accepted beat is followed by a row read.
  `SRCR_ASSERT_NXT(a_read_after, in_tvalid && in_tready, cmd.read_en, "no read after accept")

endmodule
